/* src/assert_macros.svh */
// Assertion macros used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/cdsw7_pkg.sv */
// Package with the types, constants and segment helpers of the countdown timer.
`timescale 1ns / 1ps

package cdsw7_pkg;

  localparam int CountW = 19;
  localparam int SwW    = 10;

  localparam logic [CountW-1:0] FULL_COUNT     = 19'd360000;
  localparam logic [12:0]       CENTIS_PER_MIN = 13'd6000;
  localparam logic [6:0]        CENTIS_PER_SEC = 7'd100;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_KEY  = 1'b1;

  localparam logic [3:0] KEY_RUN     = 4'b0001;
  localparam logic [3:0] KEY_SET_CS  = 4'b0010;
  localparam logic [3:0] KEY_SET_SEC = 4'b0100;
  localparam logic [3:0] KEY_SET_MIN = 4'b1000;

  localparam logic [7:0]  SEG_ZERO       = 8'b00111111;
  localparam logic [31:0] HEX_LOW_RESET  = {4{SEG_ZERO}};
  localparam logic [15:0] HEX_HIGH_RESET = {2{SEG_ZERO}};

  typedef struct packed {
    logic            operation;
    logic [3:0]      key_edges;
    logic [SwW-1:0]  switches;
  } cmd_t;

  typedef struct packed {
    logic [31:0] hex_low;
    logic [15:0] hex_high;
    logic        running;
  } res_t;

  // Count handed from the control stage to the display conversion.
  typedef struct packed {
    logic              refresh;
    logic              running;
    logic [CountW-1:0] count;
  } conv_req_t;

  function automatic logic [7:0] seg_of(input logic [3:0] digit);
    logic [7:0] seg;
    case (digit)
      4'd0:    seg = 8'h3F;
      4'd1:    seg = 8'h06;
      4'd2:    seg = 8'h5B;
      4'd3:    seg = 8'h4F;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'h6D;
      4'd6:    seg = 8'h7D;
      4'd7:    seg = 8'h07;
      4'd8:    seg = 8'h7F;
      4'd9:    seg = 8'h6F;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

  // Two digits of a value below 100 as {tens, ones} segment bytes.
  // The tens digit is taken as (v * 205) >> 11, exact for this range.
  function automatic logic [15:0] seg_pair(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    prod = 15'(v) * 15'd205;
    tens = prod[14:11];
    ones = v - 7'(tens) * 7'd10;
    return {seg_of(tens), seg_of(ones[3:0])};
  endfunction

endpackage

/* src/cdsw7_ctrl.sv */
// Control stage: run flag, time settings and the remaining count.
`timescale 1ns / 1ps

module cdsw7_ctrl
  import cdsw7_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_stall,
  input  cmd_t      cmd,
  output logic      conv_valid,
  input  logic      conv_stall,
  output conv_req_t conv
);

  logic [CountW-1:0] count;
  logic [SwW-1:0]    set_cs;
  logic [SwW-1:0]    set_sec;
  logic [SwW-1:0]    set_min;
  logic              run;

  logic [CountW-1:0] count_next;
  logic [SwW-1:0]    set_cs_next;
  logic [SwW-1:0]    set_sec_next;
  logic [SwW-1:0]    set_min_next;
  logic              run_next;
  logic              refresh;
  logic [22:0]       sum;
  logic              load;
  logic              accept;

  assign load      = !conv_valid || !conv_stall;
  assign cmd_stall = !load;
  assign accept    = cmd_valid && load;

  always_comb begin
    count_next   = count;
    set_cs_next  = set_cs;
    set_sec_next = set_sec;
    set_min_next = set_min;
    run_next     = run;
    refresh      = 1'b0;
    if (cmd.operation == OP_TICK) begin
      if (run) begin
        count_next = (count <= 19'd1) ? FULL_COUNT : count - 19'd1;
        refresh    = 1'b1;
      end
    end else begin
      case (cmd.key_edges)
        KEY_RUN: begin
          run_next = !run;
          refresh  = 1'b1;
        end
        KEY_SET_CS:  set_cs_next  = cmd.switches;
        KEY_SET_SEC: set_sec_next = cmd.switches;
        KEY_SET_MIN: set_min_next = cmd.switches;
        default: ;
      endcase
    end
    sum = 23'(set_min_next) * 23'(CENTIS_PER_MIN)
        + 23'(set_sec_next) * 23'(CENTIS_PER_SEC)
        + 23'(set_cs_next);
    // A setting key reloads the count, clamped so the digits stay in range.
    if (cmd.operation == OP_KEY &&
        (cmd.key_edges == KEY_SET_CS || cmd.key_edges == KEY_SET_SEC ||
         cmd.key_edges == KEY_SET_MIN)) begin
      count_next = (sum > 23'(FULL_COUNT)) ? FULL_COUNT : sum[CountW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= FULL_COUNT;
      set_cs     <= '0;
      set_sec    <= '0;
      set_min    <= '0;
      run        <= 1'b0;
      conv_valid <= 1'b0;
    end else if (load) begin
      conv_valid <= cmd_valid;
      if (accept) begin
        count        <= count_next;
        set_cs       <= set_cs_next;
        set_sec      <= set_sec_next;
        set_min      <= set_min_next;
        run          <= run_next;
        conv.refresh <= refresh;
        conv.running <= run_next;
        conv.count   <= count_next;
      end
    end
  end

endmodule

/* src/cdsw7_conv.sv */
// Display pipeline: splits the count into minutes, seconds and centiseconds.
`timescale 1ns / 1ps

module cdsw7_conv
  import cdsw7_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      conv_valid,
  output logic      conv_stall,
  input  conv_req_t conv,
  output logic      res_valid,
  input  logic      res_stall,
  output res_t      res
);

  // Stage 2: estimate of count / 100.
  logic              s2_valid, s2_refresh, s2_run;
  logic [CountW-1:0] s2_count;
  logic [11:0]       s2_q;
  // Stage 3: centiseconds and total seconds.
  logic              s3_valid, s3_refresh, s3_run;
  logic [6:0]        s3_cs;
  logic [11:0]       s3_sect;
  // Stage 4: estimate of seconds / 60.
  logic              s4_valid, s4_refresh, s4_run;
  logic [6:0]        s4_cs;
  logic [11:0]       s4_sect;
  logic [5:0]        s4_mest;
  // Stage 5: final minutes, seconds, centiseconds.
  logic              s5_valid, s5_refresh, s5_run;
  logic [6:0]        s5_cs;
  logic [5:0]        s5_sec;
  logic [5:0]        s5_min;

  logic out_ready, s5_ready, s4_ready, s3_ready, s2_ready;

  logic [34:0]       prod1;
  logic [CountW-1:0] rem1;
  logic [22:0]       prod2;
  logic [11:0]       rem2;
  logic [6:0]        cs_next;
  logic [11:0]       sect_next;
  logic [5:0]        sec_next;
  logic [5:0]        min_next;

  assign out_ready  = !res_valid || !res_stall;
  assign s5_ready   = !s5_valid || out_ready;
  assign s4_ready   = !s4_valid || s5_ready;
  assign s3_ready   = !s4_valid || s4_ready ? (!s3_valid || s4_ready) : !s3_valid;
  assign s2_ready   = !s2_valid || s3_ready;
  assign conv_stall = !s2_ready;

  always_comb begin
    // The reciprocal estimates run at most one low and are corrected below.
    prod1 = 35'(conv.count) * 35'd41943;
    rem1  = s2_count - 19'(s2_q) * 19'(CENTIS_PER_SEC);
    if (rem1 >= 19'(CENTIS_PER_SEC)) begin
      cs_next   = 7'(rem1 - 19'(CENTIS_PER_SEC));
      sect_next = s2_q + 12'd1;
    end else begin
      cs_next   = rem1[6:0];
      sect_next = s2_q;
    end
    prod2 = 23'(s3_sect) * 23'd1092;
    rem2  = s4_sect - 12'(s4_mest) * 12'd60;
    if (rem2 >= 12'd60) begin
      sec_next = 6'(rem2 - 12'd60);
      min_next = s4_mest + 6'd1;
    end else begin
      sec_next = rem2[5:0];
      min_next = s4_mest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      s4_valid     <= 1'b0;
      s5_valid     <= 1'b0;
      res_valid    <= 1'b0;
      res.hex_low  <= HEX_LOW_RESET;
      res.hex_high <= HEX_HIGH_RESET;
      res.running  <= 1'b0;
    end else begin
      if (s2_ready) begin
        s2_valid   <= conv_valid;
        s2_refresh <= conv.refresh;
        s2_run     <= conv.running;
        s2_count   <= conv.count;
        s2_q       <= prod1[33:22];
      end
      if (s3_ready) begin
        s3_valid   <= s2_valid;
        s3_refresh <= s2_refresh;
        s3_run     <= s2_run;
        s3_cs      <= cs_next;
        s3_sect    <= sect_next;
      end
      if (s4_ready) begin
        s4_valid   <= s3_valid;
        s4_refresh <= s3_refresh;
        s4_run     <= s3_run;
        s4_cs      <= s3_cs;
        s4_sect    <= s3_sect;
        s4_mest    <= prod2[21:16];
      end
      if (s5_ready) begin
        s5_valid   <= s4_valid;
        s5_refresh <= s4_refresh;
        s5_run     <= s4_run;
        s5_cs      <= s4_cs;
        s5_sec     <= sec_next;
        s5_min     <= min_next;
      end
      // The result register doubles as the display state, so a request that
      // does not refresh repeats the digits last shown.
      if (out_ready) begin
        res_valid <= s5_valid;
        if (s5_valid) begin
          res.running <= s5_run;
          if (s5_refresh) begin
            res.hex_low  <= {seg_pair({1'b0, s5_sec}), seg_pair(s5_cs)};
            res.hex_high <= seg_pair({1'b0, s5_min});
          end
        end
      end
    end
  end

endmodule

/* src/countdown_stopwatch_7seg.sv */
// Top level of the centisecond countdown timer with six seven-segment digits.
//
// Requests arrive on cmd (cmd_valid / cmd_stall): a timer tick, or a
// pushbutton edge event carrying key_edges and the switch value. Key 0
// toggles run and stop; keys 1 to 3 set centiseconds, seconds or minutes
// and reload the count, clamped to 60:00.00. Each request yields exactly
// one result on res (res_valid / res_stall): the segment bytes of MM SS cc
// and the run flag after that request.
// A request is taken in any cycle in which cmd_stall is low, one per cycle
// sustained while res_stall stays low. Its result passes through one control
// stage, then four stages that split the count with two reciprocal
// multiplications, then the result register.
// While res_stall holds a result, later requests keep filling the empty
// stages; cmd_stall rises only once every stage holds a request.
// Reset stops the timer, loads 60:00.00 into the count, clears the
// settings and shows all zeros until the first refresh.
`timescale 1ns / 1ps

module countdown_stopwatch_7seg
  import cdsw7_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  cmd_t cmd,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  logic      conv_valid;
  logic      conv_stall;
  conv_req_t conv;

  cdsw7_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd),
    .conv_valid (conv_valid),
    .conv_stall (conv_stall),
    .conv       (conv)
  );

  cdsw7_conv u_conv (
    .clk        (clk),
    .rst        (rst),
    .conv_valid (conv_valid),
    .conv_stall (conv_stall),
    .conv       (conv),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res)
  );

endmodule

/* src/cdsw7_checker.sv */
// Port checker for the countdown timer, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cdsw7_checker
  import cdsw7_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic res_valid,
  input logic res_stall,
  input res_t res
);

  logic [7:0] min_tens;
  logic [7:0] sec_tens;
  logic       min_tens_ok;
  logic       sec_tens_ok;

  assign min_tens = res.hex_high[15:8];
  assign sec_tens = res.hex_low[31:24];

  // Minutes never pass 60, so the tens digit of minutes is at most 6.
  assign min_tens_ok = (min_tens == 8'h3F) || (min_tens == 8'h06) || (min_tens == 8'h5B) ||
                       (min_tens == 8'h4F) || (min_tens == 8'h66) || (min_tens == 8'h6D) ||
                       (min_tens == 8'h7D);

  // Seconds stay below 60.
  assign sec_tens_ok = (sec_tens == 8'h3F) || (sec_tens == 8'h06) || (sec_tens == 8'h5B) ||
                       (sec_tens == 8'h4F) || (sec_tens == 8'h66) || (sec_tens == 8'h6D);

  // A stalled result stays put.
  `ASSERT_CLK(a_res_hold, res_valid && res_stall |=> res_valid && $stable(res), "result changed while stalled")

  // Reset empties the result register.
  `ASSERT_ANY(a_rst_empty, rst |=> !res_valid, "result valid right after reset")

  `ASSERT_CLK(a_min_tens, res_valid |-> min_tens_ok, "bad minute tens digit")

  `ASSERT_CLK(a_sec_tens, res_valid |-> sec_tens_ok, "bad second tens digit")

endmodule

bind countdown_stopwatch_7seg cdsw7_checker u_checker (.*);

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench that compares the countdown timer's displays with a predicted timer.
module tb_top;
  import cdsw7_pkg::*;

  localparam int HoldCycles     = 80;
  localparam int RandomRequests = 400;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_mode_e;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd       = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  stall_mode_e stall_mode = STALL_NONE;
  int hold_serial = 0;
  int seen_serial = 0;
  int hold_left   = 0;
  int stall_phase = 0;
  int error_count = 0;

  res_t pending_displays[$];

  // Predicted timer state.
  logic [CountW-1:0] count_left;
  logic [SwW-1:0]    set_cs_sw;
  logic [SwW-1:0]    set_sec_sw;
  logic [SwW-1:0]    set_min_sw;
  logic              timer_running;
  logic [31:0]       shown_low;
  logic [15:0]       shown_high;

  countdown_stopwatch_7seg dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always #4 clk = ~clk;

  function automatic logic [7:0] digit_segments(input int digit);
    case (digit)
      0:       return 8'h3F;
      1:       return 8'h06;
      2:       return 8'h5B;
      3:       return 8'h4F;
      4:       return 8'h66;
      5:       return 8'h6D;
      6:       return 8'h7D;
      7:       return 8'h07;
      8:       return 8'h7F;
      9:       return 8'h6F;
      default: return 8'h00;
    endcase
  endfunction

  function automatic void refresh_shown();
    int total;
    int mins;
    int secs;
    int centis;
    total  = int'(count_left);
    mins   = total / int'(CENTIS_PER_MIN);
    secs   = (total / int'(CENTIS_PER_SEC)) % 60;
    centis = total % int'(CENTIS_PER_SEC);
    shown_high = {digit_segments(mins / 10), digit_segments(mins % 10)};
    shown_low  = {digit_segments(secs / 10), digit_segments(secs % 10),
                  digit_segments(centis / 10), digit_segments(centis % 10)};
  endfunction

  function automatic void reload_count();
    int sum;
    sum = int'(set_min_sw) * int'(CENTIS_PER_MIN) + int'(set_sec_sw) * int'(CENTIS_PER_SEC)
          + int'(set_cs_sw);
    if (sum > int'(FULL_COUNT)) count_left = FULL_COUNT;
    else count_left = CountW'(sum);
  endfunction

  // Applies one request to the predicted timer and returns the display it should produce.
  function automatic res_t advance_timer(input cmd_t item);
    res_t shown;
    if (item.operation == OP_TICK) begin
      if (timer_running) begin
        if (count_left <= 1) count_left = FULL_COUNT;
        else count_left = count_left - 1'b1;
        refresh_shown();
      end
    end else begin
      case (item.key_edges)
        KEY_RUN: begin
          timer_running = ~timer_running;
          refresh_shown();
        end
        KEY_SET_CS: begin
          set_cs_sw = item.switches;
          reload_count();
        end
        KEY_SET_SEC: begin
          set_sec_sw = item.switches;
          reload_count();
        end
        KEY_SET_MIN: begin
          set_min_sw = item.switches;
          reload_count();
        end
        default: ;
      endcase
    end
    shown.hex_low  = shown_low;
    shown.hex_high = shown_high;
    shown.running  = timer_running;
    return shown;
  endfunction

  function automatic cmd_t make_request(input logic op, input logic [3:0] keys,
                                        input logic [SwW-1:0] sw);
    cmd_t item;
    item.operation = op;
    item.key_edges = keys;
    item.switches  = sw;
    return item;
  endfunction

  // Mostly ticks while running, with settings biased toward small counts so the
  // countdown wraps now and then; the rest is run toggles and stray key patterns.
  function automatic cmd_t random_request();
    int pick;
    logic [SwW-1:0] sw;
    logic [3:0] set_keys;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 3) == 0) sw = SwW'($urandom);
    else if ($urandom_range(0, 1) == 1) sw = SwW'($urandom_range(0, 99));
    else sw = SwW'($urandom_range(0, 3));
    case ($urandom_range(0, 2))
      0:       set_keys = KEY_SET_CS;
      1:       set_keys = KEY_SET_SEC;
      default: set_keys = KEY_SET_MIN;
    endcase
    if (!timer_running && pick < 30) return make_request(OP_KEY, KEY_RUN, SwW'($urandom));
    if (pick < 60) return make_request(OP_TICK, 4'($urandom), SwW'($urandom));
    if (pick < 66) return make_request(OP_KEY, KEY_RUN, SwW'($urandom));
    if (pick < 85) return make_request(OP_KEY, set_keys, sw);
    return make_request(OP_KEY, 4'($urandom), SwW'($urandom));
  endfunction

  // Holds valid high with a steady payload until the request is taken.
  task automatic send_request(input cmd_t item);
    cmd_valid <= 1'b1;
    cmd       <= item;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    pending_displays.push_back(advance_timer(item));
  endtask

  task automatic pause_requests(input int cycles);
    if (cycles > 0) begin
      cmd_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending_displays.size() != 0) @(posedge clk);
  endtask

  // Receiver: a long hold-off whenever hold_serial moves, otherwise the chosen pattern.
  always @(posedge clk) begin
    stall_phase <= (stall_phase + 1) % 7;
    if (rst) begin
      res_stall <= 1'b0;
    end else if (hold_serial != seen_serial) begin
      seen_serial <= hold_serial;
      hold_left   <= HoldCycles;
      res_stall   <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_stall <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_RANDOM:  res_stall <= ($urandom_range(0, 2) == 0);
        STALL_PATTERN: res_stall <= (stall_phase < 3);
        default:       res_stall <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_displays.size() == 0) begin
        $error("unexpected result: hex_low %h hex_high %h running %b",
               res.hex_low, res.hex_high, res.running);
        error_count++;
      end else begin
        want = pending_displays.pop_front();
        if (res.hex_low !== want.hex_low) begin
          $error("hex_low: expected %h, got %h", want.hex_low, res.hex_low);
          error_count++;
        end
        if (res.hex_high !== want.hex_high) begin
          $error("hex_high: expected %h, got %h", want.hex_high, res.hex_high);
          error_count++;
        end
        if (res.running !== want.running) begin
          $error("running: expected %b, got %b", want.running, res.running);
          error_count++;
        end
      end
    end
  end

  // Ticks while stopped and key patterns that are not a single key change nothing.
  task automatic test_ignored_requests();
    stall_mode <= STALL_RANDOM;
    send_request(make_request(OP_TICK, 4'hF, '1));
    send_request(make_request(OP_KEY, 4'h0, '1));
    send_request(make_request(OP_KEY, 4'hF, '0));
    send_request(make_request(OP_KEY, 4'h3, 10'h155));
    send_request(make_request(OP_KEY, 4'hA, 10'h2AA));
  endtask

  // Setting keys leave the display alone until the run key refreshes it.
  task automatic test_set_and_run();
    send_request(make_request(OP_KEY, KEY_SET_CS, SwW'(99)));
    send_request(make_request(OP_KEY, KEY_SET_SEC, SwW'(59)));
    send_request(make_request(OP_KEY, KEY_SET_MIN, SwW'(59)));
    send_request(make_request(OP_KEY, KEY_RUN, '0));
    send_request(make_request(OP_TICK, 4'h5, '1));
    send_request(make_request(OP_KEY, KEY_RUN, '1));
    send_request(make_request(OP_TICK, 4'h0, '0));
  endtask

  // The weighted sum of full switch values clamps at sixty minutes.
  task automatic test_saturation();
    send_request(make_request(OP_KEY, KEY_SET_MIN, '1));
    send_request(make_request(OP_KEY, KEY_SET_SEC, '1));
    send_request(make_request(OP_KEY, KEY_SET_CS, '1));
    send_request(make_request(OP_KEY, KEY_RUN, '0));
    send_request(make_request(OP_TICK, 4'h0, '0));
  endtask

  // A tick at a count of one or zero reloads the full count.
  task automatic test_reload_at_end();
    send_request(make_request(OP_KEY, KEY_SET_MIN, '0));
    send_request(make_request(OP_KEY, KEY_SET_SEC, '0));
    send_request(make_request(OP_KEY, KEY_SET_CS, SwW'(2)));
    send_request(make_request(OP_TICK, 4'h0, '0));
    send_request(make_request(OP_TICK, 4'h0, '0));
    send_request(make_request(OP_KEY, KEY_SET_CS, '0));
    send_request(make_request(OP_TICK, 4'h0, '0));
    wait_for_results();
  endtask

  // The receiver holds off long enough for the pipeline to fill and stall requests.
  task automatic test_backpressure();
    stall_mode  <= STALL_NONE;
    hold_serial <= hold_serial + 1;
    repeat (24) send_request(random_request());
    wait_for_results();
  endtask

  task automatic test_random_run();
    int sent;
    int burst;
    sent = 0;
    while (sent < RandomRequests) begin
      if ($urandom_range(0, 9) == 0) stall_mode <= stall_mode_e'($urandom_range(0, 2));
      if ($urandom_range(0, 15) == 0) begin
        // A short countdown from a small count that can run through the wrap to the full count.
        send_request(make_request(OP_KEY, KEY_SET_MIN, '0));
        send_request(make_request(OP_KEY, KEY_SET_SEC, '0));
        send_request(make_request(OP_KEY, KEY_SET_CS, SwW'($urandom_range(0, 4))));
        sent += 3;
        if (!timer_running) begin
          send_request(make_request(OP_KEY, KEY_RUN, SwW'($urandom)));
          sent++;
        end
        burst = $urandom_range(3, 8);
        repeat (burst) send_request(make_request(OP_TICK, 4'($urandom), SwW'($urandom)));
        sent += burst;
      end else begin
        burst = $urandom_range(1, 12);
        repeat (burst) send_request(random_request());
        sent += burst;
      end
      if ($urandom_range(0, 3) != 0) pause_requests($urandom_range(1, 6));
    end
    wait_for_results();
  endtask

  initial begin
    count_left    = FULL_COUNT;
    set_cs_sw     = '0;
    set_sec_sw    = '0;
    set_min_sw    = '0;
    timer_running = 1'b0;
    shown_low     = HEX_LOW_RESET;
    shown_high    = HEX_HIGH_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_ignored_requests();
    test_set_and_run();
    test_saturation();
    test_reload_at_end();
    test_backpressure();
    test_random_run();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("countdown_stopwatch_7seg: match");
    end else begin
      $display("countdown_stopwatch_7seg: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("countdown_stopwatch_7seg: mismatch");
    $finish;
  end

endmodule

/* countdown_stopwatch_7seg.f */
+incdir+src
src/cdsw7_pkg.sv
src/cdsw7_ctrl.sv
src/cdsw7_conv.sv
src/countdown_stopwatch_7seg.sv
src/cdsw7_checker.sv
verif/tb_top.sv
